// File: rtl/fasta_record_validator_core_macros.svh
// ---------------------------------------------------------------------------
// fasta record validator assertion macros
// concurrent check shorthands clocked on clock, disabled during reset
// ---------------------------------------------------------------------------
`ifndef FASTA_RECORD_VALIDATOR_CORE_MACROS_SVH
`define FASTA_RECORD_VALIDATOR_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define FRV_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FRV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/frv_pkg.sv
// ---------------------------------------------------------------------------
// frv_pkg
// shared codes, character constants and class tests for the fasta validator
// ---------------------------------------------------------------------------
package frv_pkg;

   localparam int CHAR_W  = 8;
   localparam int KIND_W  = 2;
   localparam int ERR_W   = 4;
   localparam int PHASE_W = 3;

   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [KIND_W-1:0]  kind_type;
   typedef logic [ERR_W-1:0]   err_type;
   typedef logic [PHASE_W-1:0] phase_type;

   // parser phases
   localparam phase_type PH_START    = 3'd0;
   localparam phase_type PH_LABEL0   = 3'd1;
   localparam phase_type PH_LABEL    = 3'd2;
   localparam phase_type PH_META     = 3'd3;
   localparam phase_type PH_HDR_LINE = 3'd4;
   localparam phase_type PH_COMMENT  = 3'd5;
   localparam phase_type PH_SEQ_LINE = 3'd6;
   localparam phase_type PH_SEQ      = 3'd7;

   // error codes
   localparam err_type ERR_NONE        = 4'd0;
   localparam err_type ERR_NO_GT       = 4'd1;
   localparam err_type ERR_EMPTY_LABEL = 4'd2;
   localparam err_type ERR_LABEL_END   = 4'd3;
   localparam err_type ERR_HEADER_END  = 4'd4;
   localparam err_type ERR_SYMBOL      = 4'd5;
   localparam err_type ERR_NO_NEWLINE  = 4'd6;
   localparam err_type ERR_EMPTY_LINE  = 4'd7;
   localparam err_type ERR_EMPTY_SEQ   = 4'd8;

   // byte classes
   localparam kind_type KIND_NONE  = 2'd0;
   localparam kind_type KIND_LABEL = 2'd1;
   localparam kind_type KIND_META  = 2'd2;
   localparam kind_type KIND_SITE  = 2'd3;

   // structural characters
   localparam char_type CHAR_GT      = 8'h3E;
   localparam char_type CHAR_SEMI    = 8'h3B;
   localparam char_type CHAR_NEWLINE = 8'h0A;
   localparam char_type CHAR_SPACE   = 8'h20;

   function automatic logic is_graphic(input char_type c);
      return c inside {[8'h21:8'h7E]};
   endfunction

   function automatic logic is_printable(input char_type c);
      return c inside {[8'h20:8'h7E]};
   endfunction

endpackage

// File: rtl/fasta_record_validator_core.sv
// ---------------------------------------------------------------------------
// fasta_record_validator_core
// byte-serial checker and classifier for fasta text streams
// ---------------------------------------------------------------------------
// One request is one byte of fasta text or an end-of-stream mark; each gives
// exactly one response in the next cycle, carrying the byte, its class (label,
// metadata, sequence site or structural), record begin/end flags and the
// error status. A request is taken in every cycle: the next parser state is
// a combinational decode of the phase register and the byte, and the response
// sits in an output register, so the request side stalls only while that
// register holds a response that the receiver is stalling. The first error
// is latched and reported on every later response until reset; an
// end-of-stream mark at a line start after a complete record returns the
// parser to expecting '>' so streams may be concatenated.
// ---------------------------------------------------------------------------
module fasta_record_validator_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  frv_pkg::char_type req_char_in,
   input  logic              req_stream_end,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output frv_pkg::char_type rsp_char_out,
   output frv_pkg::kind_type rsp_char_kind,
   output logic              rsp_record_begin,
   output logic              rsp_record_end,
   output frv_pkg::err_type  rsp_error_code,
   output logic              rsp_halted
);
   import frv_pkg::*;

   phase_type phase_ff, phase_in;
   logic      sites_ff, sites_in;
   err_type   error_ff, error_in;

   logic      rsp_valid_ff;
   char_type  char_ff, char_in;
   kind_type  kind_ff, kind_in;
   logic      begin_ff, begin_in;
   logic      end_ff, end_in;

   logic      accept;
   err_type   err_new;

   // stall only while a response waits and is itself stalled
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // next-state decode for one byte or end mark
   always_comb begin
      char_in  = req_stream_end ? '0 : req_char_in;
      phase_in = phase_ff;
      sites_in = sites_ff;
      kind_in  = KIND_NONE;
      begin_in = 1'b0;
      end_in   = 1'b0;
      err_new  = ERR_NONE;

      case (phase_ff)
         PH_START: begin
            if (!req_stream_end) begin
               if (char_in == CHAR_GT) begin
                  begin_in = 1'b1;
                  phase_in = PH_LABEL0;
               end else begin
                  err_new = ERR_NO_GT;
               end
            end
         end
         PH_LABEL0: begin
            if (!req_stream_end && is_graphic(char_in)) begin
               kind_in  = KIND_LABEL;
               phase_in = PH_LABEL;
            end else begin
               err_new = ERR_EMPTY_LABEL;
            end
         end
         PH_LABEL: begin
            if (req_stream_end)                 err_new  = ERR_LABEL_END;
            else if (is_graphic(char_in))       kind_in  = KIND_LABEL;
            else if (char_in == CHAR_SPACE)     phase_in = PH_META;
            else if (char_in == CHAR_NEWLINE)   phase_in = PH_HDR_LINE;
            else                                err_new  = ERR_LABEL_END;
         end
         PH_META: begin
            if (req_stream_end)                 err_new  = ERR_HEADER_END;
            else if (is_printable(char_in))     kind_in  = KIND_META;
            else if (char_in == CHAR_NEWLINE)   phase_in = PH_HDR_LINE;
            else                                err_new  = ERR_HEADER_END;
         end
         PH_COMMENT: begin
            if (req_stream_end)                 err_new  = ERR_HEADER_END;
            else if (char_in == CHAR_NEWLINE)   phase_in = PH_HDR_LINE;
            else if (!is_printable(char_in))    err_new  = ERR_HEADER_END;
         end
         PH_HDR_LINE, PH_SEQ_LINE: begin
            // comment lines only directly after the header
            if (phase_ff == PH_HDR_LINE && !req_stream_end && char_in == CHAR_SEMI) begin
               phase_in = PH_COMMENT;
            end else if (req_stream_end || char_in == CHAR_GT) begin
               // record closes at line start
               if (!sites_ff) begin
                  err_new = ERR_EMPTY_SEQ;
               end else begin
                  end_in   = 1'b1;
                  sites_in = 1'b0;
                  if (req_stream_end) begin
                     phase_in = PH_START;
                  end else begin
                     begin_in = 1'b1;
                     phase_in = PH_LABEL0;
                  end
               end
            end else if (is_graphic(char_in)) begin
               kind_in  = KIND_SITE;
               sites_in = 1'b1;
               phase_in = PH_SEQ;
            end else if (char_in == CHAR_NEWLINE) begin
               err_new = ERR_EMPTY_LINE;
            end else begin
               err_new = ERR_SYMBOL;
            end
         end
         PH_SEQ: begin
            if (req_stream_end)                 err_new  = ERR_NO_NEWLINE;
            else if (is_graphic(char_in))       kind_in  = KIND_SITE;
            else if (char_in == CHAR_NEWLINE)   phase_in = PH_SEQ_LINE;
            else                                err_new  = ERR_SYMBOL;
         end
         default: begin
            phase_in = PH_START;
         end
      endcase

      error_in = error_ff;
      // error or halt: flags and class cleared, state frozen
      if (error_ff != ERR_NONE || err_new != ERR_NONE) begin
         if (error_ff == ERR_NONE) error_in = err_new;
         phase_in = phase_ff;
         sites_in = sites_ff;
         kind_in  = KIND_NONE;
         begin_in = 1'b0;
         end_in   = 1'b0;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         sites_ff <= 1'b0;
         error_ff <= ERR_NONE;
      end else if (accept) begin
         phase_ff <= phase_in;
         sites_ff <= sites_in;
         error_ff <= error_in;
      end
   end

   // response register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff  <= char_in;
         kind_ff  <= kind_in;
         begin_ff <= begin_in;
         end_ff   <= end_in;
      end
   end

   // latched error is shown from the state register itself
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_char_out     = char_ff;
   assign rsp_char_kind    = kind_ff;
   assign rsp_record_begin = begin_ff;
   assign rsp_record_end   = end_ff;
   assign rsp_error_code   = error_ff;
   assign rsp_halted       = (error_ff != ERR_NONE);

endmodule

// File: rtl/frv_checker.sv
// ---------------------------------------------------------------------------
// frv_checker
// port-level assertions for the fasta record validator, bound to the top
// ---------------------------------------------------------------------------
`include "fasta_record_validator_core_macros.svh"

module frv_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input frv_pkg::char_type rsp_char_out,
   input frv_pkg::kind_type rsp_char_kind,
   input logic              rsp_record_begin,
   input logic              rsp_record_end,
   input frv_pkg::err_type  rsp_error_code,
   input logic              rsp_halted
);
   import frv_pkg::*;

   // request side stalls only behind a stalled response
   `FRV_ASSERT_SAME(a_req_stall_cause, req_stall, rsp_valid && rsp_stall, "request stalled without a stalled response")

   // a stalled response keeps its payload
   `FRV_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_char_out) && $stable(rsp_char_kind) && $stable(rsp_record_begin) && $stable(rsp_record_end), "stalled response changed")

   // halted flag mirrors the error code
   `FRV_ASSERT_SAME(a_halt_code, rsp_valid, rsp_halted == (rsp_error_code != ERR_NONE), "halted flag disagrees with error code")

   // a halted response carries no class and no record flags
   `FRV_ASSERT_SAME(a_halt_quiet, rsp_valid && rsp_halted, rsp_char_kind == KIND_NONE && !rsp_record_begin && !rsp_record_end, "halted response reports activity")

   // a record begins only on '>'
   `FRV_ASSERT_SAME(a_begin_gt, rsp_valid && rsp_record_begin, rsp_char_out == CHAR_GT, "record begin on a byte other than '>'")

endmodule

bind fasta_record_validator_core frv_checker u_frv_checker (.*);
